// File: src/spq_pkg.sv
// Shared types and constants of the sorted priority queue.
`default_nettype none

package spq_pkg;

    // Sizes of the queue and of the item fields.
    localparam int QUEUE_DEPTH = 16;
    localparam int TAG_BITS    = 16;
    localparam int PRIO_W      = 32;
    localparam int STATUS_W    = 3;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);

    // Operation codes carried by an input item.
    typedef enum logic [1:0] {
        OP_ENQUEUE = 2'd0,
        OP_DEQUEUE = 2'd1,
        OP_CHANGE  = 2'd2,
        OP_CLEAR   = 2'd3
    } op_t;

    // Status codes carried by a result item.
    typedef enum logic [STATUS_W-1:0] {
        STAT_OK         = 3'd0,
        STAT_EMPTY      = 3'd1,
        STAT_NOT_FOUND  = 3'd2,
        STAT_NOT_URGENT = 3'd3,
        STAT_FULL       = 3'd4
    } status_t;

    // Sequencer states of the top level.
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_REMOVE,
        S_INSERT,
        S_DONE
    } state_t;

    // Command broadcast to every cell of the chain.
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_REMOVE,
        CELL_CLEAR
    } cell_op_t;

    // Contents of one cell.
    typedef struct packed {
        logic                valid;
        logic [TAG_BITS-1:0] tag;
        logic [PRIO_W-1:0]   prio;
    } entry_t;

    // Control group from the sequencer to the cells.
    typedef struct packed {
        cell_op_t            op;
        logic [TAG_BITS-1:0] new_tag;
        logic [PRIO_W-1:0]   new_prio;
        logic [IDX_W-1:0]    pos;
    } cell_ctrl_t;

    // Payload of an input item.
    typedef struct packed {
        op_t                      operation;
        logic [TAG_BITS-1:0]      item_tag;
        logic signed [PRIO_W-1:0] new_priority;
    } req_item_t;

    // Payload of a result item.
    typedef struct packed {
        status_t                  status;
        logic [TAG_BITS-1:0]      removed_tag;
        logic [TAG_BITS-1:0]      head_tag;
        logic signed [PRIO_W-1:0] head_priority;
        logic [CNT_W-1:0]         entry_count;
        logic                     is_empty;
    } rsp_item_t;

endpackage

`default_nettype wire

// File: src/spq_req_if.sv
// Request channel of the sorted priority queue.
`default_nettype none

interface spq_req_if
    import spq_pkg::*;
();
    logic      valid;
    logic      ready;
    req_item_t item;

    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

`default_nettype wire

// File: src/spq_rsp_if.sv
// Result channel of the sorted priority queue.
`default_nettype none

interface spq_rsp_if
    import spq_pkg::*;
();
    logic      valid;
    logic      ready;
    rsp_item_t item;

    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

`default_nettype wire

// File: src/sorted_priority_queue.sv
// Sorted priority queue top level: sequencer, result register and the chain of cells.
//
// The queue holds up to QUEUE_DEPTH tagged entries in a chain of cells kept sorted by
// signed priority, smaller first, with equal priorities in arrival order. Every cell
// compares its own priority with the incoming one, so an insert or a removal shifts the
// chain of all cells at once. Enqueue passes through insert and then done, dequeue through
// remove and then done; clear and any item refused as full or empty go straight to done.
// Change priority scans the tags one cell per cycle through a single shared compare, then
// removes and reinserts the entry when it is found and the new priority is more urgent.
// A result waits in an output register until it is taken. The sequencer returns to idle
// as soon as the result is loaded, so the next item is accepted in the following cycle
// even while that result still waits; only the next result stalls behind it.
`default_nettype none

module sorted_priority_queue
    import spq_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    spq_req_if.sink    req,
    spq_rsp_if.source  rsp
);

    // Sequencer and item registers.
    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [CNT_W-1:0]    scan_reg, scan_next;
    logic [IDX_W-1:0]    pos_reg, pos_next;
    op_t                 op_reg, op_next;
    logic [TAG_BITS-1:0] tag_reg, tag_next;
    logic [PRIO_W-1:0]   prio_reg, prio_next;
    status_t             status_reg, status_next;
    logic [TAG_BITS-1:0] removed_reg, removed_next;
    logic                out_valid_reg, out_valid_next;
    rsp_item_t           out_reg, out_next;

    // Chain of cells.
    cell_ctrl_t          ctrl;
    entry_t              cell_q [QUEUE_DEPTH];
    logic                behind_q [QUEUE_DEPTH];

    // Scan read port.
    logic [IDX_W-1:0]    scan_idx;
    entry_t              scan_entry;

    assign scan_idx   = scan_reg[IDX_W-1:0];
    assign scan_entry = cell_q[scan_idx];

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++)
        begin : g_cell
            entry_t left_w;
            entry_t right_w;
            logic   left_behind_w;

            if (gi == 0)
            begin : g_first
                assign left_w        = '0;
                assign left_behind_w = 1'b1;
            end
            else
            begin : g_inner
                assign left_w        = cell_q[gi-1];
                assign left_behind_w = behind_q[gi-1];
            end

            if (gi == QUEUE_DEPTH - 1)
            begin : g_last
                assign right_w = '0;
            end
            else
            begin : g_body
                assign right_w = cell_q[gi+1];
            end

            spq_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl),
                .index       (IDX_W'(gi)),
                .left        (left_w),
                .left_behind (left_behind_w),
                .right       (right_w),
                .entry       (cell_q[gi]),
                .behind      (behind_q[gi])
            );
        end
    endgenerate

    // Items are taken only when the sequencer is idle.
    assign req.ready = (state_reg == S_IDLE);
    assign rsp.valid = out_valid_reg;
    assign rsp.item  = out_reg;

    // Next state, cell commands and result.
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        scan_next      = scan_reg;
        pos_next       = pos_reg;
        op_next        = op_reg;
        tag_next       = tag_reg;
        prio_next      = prio_reg;
        status_next    = status_reg;
        removed_next   = removed_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        ctrl.op        = CELL_HOLD;
        ctrl.new_tag   = tag_reg;
        ctrl.new_prio  = prio_reg;
        ctrl.pos       = pos_reg;

        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next      = req.item.operation;
                    tag_next     = req.item.item_tag;
                    prio_next    = req.item.new_priority;
                    status_next  = STAT_OK;
                    removed_next = '0;
                    case (req.item.operation)
                        OP_ENQUEUE:
                        begin
                            if (cnt_reg == CNT_W'(QUEUE_DEPTH))
                            begin
                                status_next = STAT_FULL;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                state_next = S_INSERT;
                            end
                        end
                        OP_DEQUEUE:
                        begin
                            if (cnt_reg == '0)
                            begin
                                status_next = STAT_EMPTY;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                removed_next = cell_q[0].tag;
                                pos_next     = '0;
                                state_next   = S_REMOVE;
                            end
                        end
                        OP_CHANGE:
                        begin
                            scan_next  = '0;
                            state_next = S_SCAN;
                        end
                        default:
                        begin
                            ctrl.op    = CELL_CLEAR;
                            cnt_next   = '0;
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (scan_reg >= cnt_reg)
                begin
                    status_next = STAT_NOT_FOUND;
                    state_next  = S_DONE;
                end
                else if (scan_entry.tag == tag_reg)
                begin
                    if ($signed(scan_entry.prio) <= $signed(prio_reg))
                    begin
                        status_next = STAT_NOT_URGENT;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        pos_next   = scan_idx;
                        state_next = S_REMOVE;
                    end
                end
                else
                begin
                    scan_next = scan_reg + CNT_W'(1);
                end
            end
            S_REMOVE:
            begin
                ctrl.op  = CELL_REMOVE;
                cnt_next = cnt_reg - CNT_W'(1);
                if (op_reg == OP_CHANGE)
                begin
                    state_next = S_INSERT;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_INSERT:
            begin
                ctrl.op    = CELL_INSERT;
                cnt_next   = cnt_reg + CNT_W'(1);
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next       = 1'b1;
                    out_next.status      = status_reg;
                    out_next.removed_tag = removed_reg;
                    out_next.entry_count = cnt_reg;
                    out_next.is_empty    = (cnt_reg == '0);
                    if (cnt_reg != '0)
                    begin
                        out_next.head_tag      = cell_q[0].tag;
                        out_next.head_priority = cell_q[0].prio;
                    end
                    else
                    begin
                        out_next.head_tag      = '0;
                        out_next.head_priority = '0;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        scan_reg    <= scan_next;
        pos_reg     <= pos_next;
        op_reg      <= op_next;
        tag_reg     <= tag_next;
        prio_reg    <= prio_next;
        status_reg  <= status_next;
        removed_reg <= removed_next;
        out_reg     <= out_next;
    end

endmodule

`default_nettype wire

// File: src/spq_cell.sv
// One cell of the sorted chain: holds one entry and moves it to or from its neighbors.
`default_nettype none

module spq_cell
    import spq_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire cell_ctrl_t       ctrl,
    input  wire logic [IDX_W-1:0] index,
    input  wire entry_t           left,
    input  wire logic             left_behind,
    input  wire entry_t           right,
    output      entry_t           entry,
    output      logic             behind
);

    logic                valid_reg;
    logic [TAG_BITS-1:0] tag_reg;
    logic [PRIO_W-1:0]   prio_reg;
    entry_t              entry_reg;
    entry_t              entry_next;

    // Current contents of this cell, gathered from its registers.
    assign entry_reg = '{valid: valid_reg, tag: tag_reg, prio: prio_reg};

    // The new entry goes behind every entry of less or equal priority.
    assign behind = entry_reg.valid &&
                    ($signed(entry_reg.prio) <= $signed(ctrl.new_prio));

    // Next contents of this cell.
    always_comb
    begin
        entry_next = entry_reg;
        case (ctrl.op)
            CELL_INSERT:
            begin
                if (!behind)
                begin
                    if (left_behind)
                    begin
                        entry_next.valid = 1'b1;
                        entry_next.tag   = ctrl.new_tag;
                        entry_next.prio  = ctrl.new_prio;
                    end
                    else
                    begin
                        entry_next = left;
                    end
                end
            end
            CELL_REMOVE:
            begin
                if (index >= ctrl.pos)
                begin
                    entry_next = right;
                end
            end
            CELL_CLEAR:
            begin
                entry_next.valid = 1'b0;
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    // The valid bit is control state; tag and priority are payload.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= entry_next.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg  <= entry_next.tag;
        prio_reg <= entry_next.prio;
    end

    assign entry = entry_reg;

endmodule

`default_nettype wire

// File: src/spq_checker.sv
// Port-level checks of the sorted priority queue, bound to the top level.
`default_nettype none

module spq_checker
    import spq_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      rsp_valid,
    input wire logic      rsp_ready,
    input wire rsp_item_t rsp_item
);

    // The count never exceeds the capacity.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_item.entry_count <= CNT_W'(QUEUE_DEPTH)))
        else $error("entry count above capacity");

    // The empty flag agrees with the count.
    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_item.is_empty == (rsp_item.entry_count == '0)))
        else $error("empty flag disagrees with count");

    // An empty queue shows a zero head.
    a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_item.is_empty) |->
            (rsp_item.head_tag == '0 && rsp_item.head_priority == '0))
        else $error("nonzero head on empty queue");

    // A removed tag only comes with a successful item.
    a_removed_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_item.removed_tag != '0) |-> (rsp_item.status == STAT_OK))
        else $error("removed tag with failing status");

    // A stalled result holds.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_item)))
        else $error("stalled result changed");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_item  (rsp.item)
);

`default_nettype wire
